@@ src/srgb_to_xyz_converter_macros.svh @@
// assertion macros for the srgb to xyz converter checker
`ifndef SRGB_TO_XYZ_CONVERTER_MACROS_SVH
`define SRGB_TO_XYZ_CONVERTER_MACROS_SVH

// property checked on every rising clock edge outside reset
`define S2X_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// condition that must never be seen
`define S2X_ASSERT_NEVER(label, cond, msg) \
  `S2X_ASSERT(label, !(cond), msg)

`endif

@@ src/s2x_pkg.sv @@
// types, constants and linearization table for the srgb to xyz converter
`timescale 1ns / 1ps

package s2x_pkg;

  localparam int ChannelBits = 8;
  localparam int OutFracBits = 10;
  localparam int OutWidth    = 17;
  localparam int LinW        = 16;
  localparam int CoefW       = 16;
  localparam int ProdW       = LinW + CoefW;
  localparam int SumW        = ProdW + 2;
  localparam int ScaledW     = SumW + 8;
  localparam int Latency     = 4;
  localparam int LutSize     = 1 << ChannelBits;
  localparam int OutShift    = 32 - OutFracBits;

  localparam logic [OutWidth-1:0] OutMax = {OutWidth{1'b1}};
  localparam logic [ScaledW-1:0] OutRound = ScaledW'(64'd1 << (31 - OutFracBits));
  localparam logic [63:0] CodeMax = 64'((64'd1 << ChannelBits) - 64'd1);
  localparam logic [63:0] One31   = 64'd1 << 31;
  localparam logic [63:0] LinDen  = 64'd2 * 64'd1292 * CodeMax;
  localparam logic [63:0] PowDen  = 64'd1055 * CodeMax;

  typedef struct packed {
    logic [ChannelBits-1:0] red;
    logic [ChannelBits-1:0] green;
    logic [ChannelBits-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [OutWidth-1:0] x_out;
    logic [OutWidth-1:0] y_out;
    logic [OutWidth-1:0] z_out;
  } xyz_t;

  typedef logic [2:0][LinW-1:0] lin_t;
  typedef logic [LutSize-1:0][LinW-1:0] lut_t;
  typedef logic [2:0][2:0][CoefW-1:0] coef_t;

  function automatic logic [CoefW-1:0] qcoef(input logic [63:0] k);
    return CoefW'((k * 64'd65536 + 64'd500000) / 64'd1000000);
  endfunction

  function automatic logic [63:0] mul31(input logic [63:0] a, input logic [63:0] b);
    return (a * b) >> 31;
  endfunction

  function automatic logic [63:0] pow5(input logic [63:0] r);
    logic [63:0] r2;
    logic [63:0] r4;
    r2 = mul31(r, r);
    r4 = mul31(r2, r2);
    return mul31(r4, r);
  endfunction

  function automatic logic [LinW-1:0] lin_value(input logic [63:0] c);
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] l31;
    logic [63:0] l16;
    if (c * 64'd100000 < 64'd4045 * CodeMax) begin
      return LinW'((64'd2 * c * 64'd6553600 + 64'd1292 * CodeMax) / LinDen);
    end
    t = ((64'd1000 * c + 64'd55 * CodeMax) << 31) / PowDen;
    if (t > One31) begin
      t = One31;
    end
    t2 = mul31(t, t);
    lo = 64'd0;
    hi = One31;
    for (int k = 0; k < 40; k++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        if (pow5(mid) <= t2) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    l31 = mul31(t2, lo);
    l16 = (l31 + (64'd1 << 14)) >> 15;
    if (l16 > 64'd65535) begin
      l16 = 64'd65535;
    end
    return LinW'(l16);
  endfunction

  function automatic lut_t build_lut();
    lut_t lut;
    for (int c = 0; c < LutSize; c++) begin
      lut[c] = lin_value(64'(c));
    end
    return lut;
  endfunction

  localparam lut_t LinLut = build_lut();

  // listed from index 2 down: rows x, y, z; within a row columns b, g, r
  localparam coef_t MatCoef = '{
    '{qcoef(64'd180423), qcoef(64'd357580), qcoef(64'd412453)},
    '{qcoef(64'd72169),  qcoef(64'd715160), qcoef(64'd212671)},
    '{qcoef(64'd950227), qcoef(64'd119193), qcoef(64'd19334)}
  };

endpackage

@@ src/s2x_matrix.sv @@
// pipelined rgb to xyz matrix with scaling, rounding and saturation
`timescale 1ns / 1ps

module s2x_matrix (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  s2x_pkg::lin_t     lin_i,
  output logic              valid_o,
  output s2x_pkg::xyz_t     xyz_o
);

  logic [2:0][2:0][s2x_pkg::ProdW-1:0] prod_d, prod_q;
  logic [2:0][s2x_pkg::SumW-1:0]       sum_d, sum_q;
  logic [2:0][s2x_pkg::OutWidth-1:0]   res_d, res_q;
  logic [2:0][s2x_pkg::ScaledW-1:0]    scaled;
  logic [2:0]                          valid_d, valid_q;

  // matrix row 2 holds x, row 0 holds z
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[i][j] = s2x_pkg::ProdW'(s2x_pkg::MatCoef[i][j] * lin_i[j]);
      end
      sum_d[i] = s2x_pkg::SumW'(prod_q[i][0]) + s2x_pkg::SumW'(prod_q[i][1])
               + s2x_pkg::SumW'(prod_q[i][2]);
      scaled[i] = s2x_pkg::ScaledW'(sum_q[i]) * s2x_pkg::ScaledW'(100)
                + s2x_pkg::OutRound;
      if ((scaled[i] >> s2x_pkg::OutShift) > s2x_pkg::ScaledW'(s2x_pkg::OutMax)) begin
        res_d[i] = s2x_pkg::OutMax;
      end else begin
        res_d[i] = s2x_pkg::OutWidth'(scaled[i] >> s2x_pkg::OutShift);
      end
    end
    valid_d = {valid_q[1:0], valid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    sum_q  <= sum_d;
    res_q  <= res_d;
  end

  assign valid_o     = valid_q[2];
  assign xyz_o.x_out = res_q[2];
  assign xyz_o.y_out = res_q[1];
  assign xyz_o.z_out = res_q[0];

endmodule

@@ src/srgb_to_xyz_converter.sv @@
// srgb to cie xyz (d65) pixel converter, top level
//
// an item is one 24-bit srgb pixel on pixel_i, accepted at a rising edge with
// start high and busy low; busy stays low, so a pixel may enter every cycle
// each pixel gives one xyz item on xyz_o (x, y, z times 100, 10 fraction
// bits, saturated), shown for one cycle with done_o high
// after the accepting edge the item is registered in each stage in turn, and
// done_o is high while its result sits in the last stage register
// throughput: one item per cycle, fixed by the four-stage pipeline
// stage 1 reads the constant linearization table, stage 2 forms the nine
// 16x16 products, stage 3 adds each row, stage 4 scales, rounds, saturates
// reset clears all valid bits: items in flight are dropped, no done_o follows
// the receiver cannot stall; results are never held back
`timescale 1ns / 1ps

module srgb_to_xyz_converter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  s2x_pkg::pixel_t pixel_i,
  output logic            done_o,
  output s2x_pkg::xyz_t   xyz_o
);

  logic          accept;
  logic          lin_valid_q;
  s2x_pkg::lin_t lin_d, lin_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // channel order in lin: 0 red, 1 green, 2 blue
  always_comb begin
    lin_d[0] = s2x_pkg::LinLut[pixel_i.red];
    lin_d[1] = s2x_pkg::LinLut[pixel_i.green];
    lin_d[2] = s2x_pkg::LinLut[pixel_i.blue];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_valid_q <= 1'b0;
    end else begin
      lin_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lin_q <= lin_d;
    end
  end

  s2x_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (lin_valid_q),
    .lin_i   (lin_q),
    .valid_o (done_o),
    .xyz_o   (xyz_o)
  );

endmodule

@@ src/s2x_checker.sv @@
// port-level checks for the srgb to xyz converter, bound to the top level
`timescale 1ns / 1ps
`include "srgb_to_xyz_converter_macros.svh"

module s2x_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input s2x_pkg::pixel_t pixel_i,
  input logic            done_o,
  input s2x_pkg::xyz_t   xyz_o
);

  `S2X_ASSERT_NEVER(a_never_busy, busy, "converter raised busy")
  `S2X_ASSERT(a_item_done, start && !busy |-> ##4 done_o, "accepted item gave no result")
  `S2X_ASSERT(a_done_has_item, done_o |-> $past(start && !busy, 4), "result without item")
  `S2X_ASSERT(a_black_zero, start && !busy && pixel_i == '0 |-> ##4 xyz_o == '0, "black not zero")

endmodule

bind srgb_to_xyz_converter s2x_checker u_s2x_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .pixel_i (pixel_i),
  .done_o  (done_o),
  .xyz_o   (xyz_o)
);

@@ tb/tb_srgb_to_xyz_converter.sv @@
// self-checking testbench for the srgb to xyz converter
`timescale 1ns / 1ps

module tb_srgb_to_xyz_converter;

  localparam int ClkPeriod = 20;
  localparam int DrainLimit = 2000;

  logic            clk_i;
  logic            rst_ni;
  logic            start;
  logic            busy;
  s2x_pkg::pixel_t pixel_i;
  logic            done_o;
  s2x_pkg::xyz_t   xyz_o;

  logic [15:0] srgb_lin_q16 [256];
  logic [63:0] xyz_coef_q16 [3][3];
  s2x_pkg::xyz_t xyz_expected [$];
  int errors;

  srgb_to_xyz_converter uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .pixel_i(pixel_i),
    .done_o (done_o),
    .xyz_o  (xyz_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  initial begin
    #(5ms);
    $display("FAIL");
    $finish;
  end

  function automatic logic [63:0] q31_mul(input logic [63:0] a, input logic [63:0] b);
    return (a * b) >> 31;
  endfunction

  function automatic logic [63:0] q31_pow5(input logic [63:0] r);
    logic [63:0] sq;
    sq = q31_mul(r, r);
    return q31_mul(q31_mul(sq, sq), r);
  endfunction

  function automatic logic [63:0] q31_root5(input logic [63:0] target);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    lo = 64'd0;
    hi = 64'd1 << 31;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 64'd1) >> 1);
      if (q31_pow5(mid) <= target) begin
        lo = mid;
      end else begin
        hi = mid - 64'd1;
      end
    end
    return lo;
  endfunction

  function automatic logic [15:0] srgb_decode(input logic [63:0] code);
    logic [63:0] m;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] l16;
    m = 64'd255;
    if (code * 64'd100000 < 64'd4045 * m) begin
      return 16'((64'd2 * code * 64'd6553600 + 64'd1292 * m) / (64'd2 * 64'd1292 * m));
    end
    t = ((64'd1000 * code + 64'd55 * m) << 31) / (64'd1055 * m);
    if (t > (64'd1 << 31)) begin
      t = 64'd1 << 31;
    end
    t2 = q31_mul(t, t);
    l16 = (q31_mul(t2, q31_root5(t2)) + (64'd1 << 14)) >> 15;
    if (l16 > 64'd65535) begin
      l16 = 64'd65535;
    end
    return l16[15:0];
  endfunction

  function automatic logic [63:0] coef_q16(input logic [63:0] millionths);
    return (millionths * 64'd65536 + 64'd500000) / 64'd1000000;
  endfunction

  function automatic logic [16:0] scale_channel(input logic [63:0] sum_q32);
    logic [63:0] v;
    v = (sum_q32 * 64'd100 + (64'd1 << (31 - s2x_pkg::OutFracBits)))
        >> (32 - s2x_pkg::OutFracBits);
    if (v > 64'(s2x_pkg::OutMax)) begin
      v = 64'(s2x_pkg::OutMax);
    end
    return v[16:0];
  endfunction

  function automatic s2x_pkg::xyz_t srgb_to_xyz(input s2x_pkg::pixel_t p);
    logic [63:0] lin [3];
    logic [63:0] sum [3];
    s2x_pkg::xyz_t res;
    lin[0] = 64'(srgb_lin_q16[p.red]);
    lin[1] = 64'(srgb_lin_q16[p.green]);
    lin[2] = 64'(srgb_lin_q16[p.blue]);
    for (int row = 0; row < 3; row++) begin
      sum[row] = 64'd0;
      for (int col = 0; col < 3; col++) begin
        sum[row] += xyz_coef_q16[row][col] * lin[col];
      end
    end
    res.x_out = scale_channel(sum[0]);
    res.y_out = scale_channel(sum[1]);
    res.z_out = scale_channel(sum[2]);
    return res;
  endfunction

  task automatic build_tables();
    for (int c = 0; c < 256; c++) begin
      srgb_lin_q16[c] = srgb_decode(64'(c));
    end
    xyz_coef_q16[0][0] = coef_q16(64'd412453);
    xyz_coef_q16[0][1] = coef_q16(64'd357580);
    xyz_coef_q16[0][2] = coef_q16(64'd180423);
    xyz_coef_q16[1][0] = coef_q16(64'd212671);
    xyz_coef_q16[1][1] = coef_q16(64'd715160);
    xyz_coef_q16[1][2] = coef_q16(64'd72169);
    xyz_coef_q16[2][0] = coef_q16(64'd19334);
    xyz_coef_q16[2][1] = coef_q16(64'd119193);
    xyz_coef_q16[2][2] = coef_q16(64'd950227);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    s2x_pkg::xyz_t want;
    if (rst_ni && done_o) begin
      if (xyz_expected.size() == 0) begin
        report_mismatch("unexpected item, x", int'(xyz_o.x_out), -1);
      end else begin
        want = xyz_expected.pop_front();
        if (xyz_o.x_out !== want.x_out) report_mismatch("x", int'(xyz_o.x_out), int'(want.x_out));
        if (xyz_o.y_out !== want.y_out) report_mismatch("y", int'(xyz_o.y_out), int'(want.y_out));
        if (xyz_o.z_out !== want.z_out) report_mismatch("z", int'(xyz_o.z_out), int'(want.z_out));
      end
    end
  end

  task automatic send_pixel(input s2x_pkg::pixel_t p, input int idle_pct);
    while (int'($urandom_range(99)) < idle_pct) begin
      @(negedge clk_i);
      start = 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    start = 1'b1;
    pixel_i = p;
    do @(posedge clk_i); while (busy);
    xyz_expected.push_back(srgb_to_xyz(p));
  endtask

  task automatic go_idle();
    @(negedge clk_i);
    start = 1'b0;
  endtask

  task automatic wait_drained();
    int cycles;
    go_idle();
    cycles = 0;
    while (xyz_expected.size() != 0 && cycles < DrainLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    if (xyz_expected.size() != 0) begin
      report_mismatch("items never returned", 0, xyz_expected.size());
      xyz_expected.delete();
    end
    repeat (s2x_pkg::Latency + 2) @(posedge clk_i);
  endtask

  function automatic logic [7:0] random_code(input int mode);
    case (mode)
      0: begin
        return 8'($urandom_range(15));
      end
      1: begin
        return $urandom_range(1) ? 8'hff : 8'h00;
      end
      2: begin
        return 8'($urandom_range(255, 240));
      end
      default: begin
        return 8'($urandom_range(255));
      end
    endcase
  endfunction

  function automatic s2x_pkg::pixel_t random_pixel();
    s2x_pkg::pixel_t p;
    int mode;
    mode = $urandom_range(9);
    p.red   = random_code(mode);
    p.green = random_code(mode);
    p.blue  = random_code(mode);
    return p;
  endfunction

  task automatic test_directed();
    logic [7:0] codes [14][3];
    codes = '{
      '{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255}, '{8'd255, 8'd0, 8'd0},
      '{8'd0, 8'd255, 8'd0}, '{8'd0, 8'd0, 8'd255}, '{8'd10, 8'd10, 8'd10},
      '{8'd11, 8'd11, 8'd11}, '{8'd10, 8'd11, 8'd12}, '{8'd1, 8'd1, 8'd1},
      '{8'd254, 8'd254, 8'd254}, '{8'd128, 8'd128, 8'd128}, '{8'd170, 8'd85, 8'd51},
      '{8'd85, 8'd170, 8'd204}, '{8'd255, 8'd11, 8'd10}
    };
    for (int i = 0; i < 14; i++) begin
      send_pixel('{red: codes[i][0], green: codes[i][1], blue: codes[i][2]}, 0);
    end
    wait_drained();
  endtask

  task automatic test_random(input int count, input int idle_pct);
    for (int i = 0; i < count; i++) begin
      send_pixel(random_pixel(), idle_pct);
    end
    wait_drained();
  endtask

  task automatic test_pause_until_empty();
    for (int i = 0; i < 100; i++) begin
      send_pixel(random_pixel(), 0);
      if (i % 25 == 24) begin
        wait_drained();
      end
    end
    wait_drained();
  endtask

  initial begin
    errors = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    pixel_i = '0;
    build_tables();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random(500, 0);
    test_random(500, 77);
    test_random(500, 36);
    test_pause_until_empty();

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ srgb_to_xyz_converter.f @@
+incdir+src
src/s2x_pkg.sv
src/s2x_matrix.sv
src/srgb_to_xyz_converter.sv
src/s2x_checker.sv
tb/tb_srgb_to_xyz_converter.sv
